### rtl/core/htcp_pkg.sv
// shared constants, types and datapath helpers for the tile corner projection
// no dependencies
package htcp_pkg;

    localparam int TILE_SIZE        = 64;
    localparam int CORNER_FRAC_BITS = 6;
    localparam int DIV_SHIFT        = 14;
    localparam int CORNER_CLAMP     = 524287;

    localparam int TW        = 15;
    localparam int OW        = 22;
    localparam int HW        = 32;
    localparam int NW        = 64;
    localparam int DW        = 31;
    localparam int QW        = 32;
    localparam int VW        = 42;
    localparam int NCOR      = 4;
    localparam int DIV_STEPS = QW;
    localparam int NPIPE     = 5 + DIV_STEPS;
    localparam int IN_DW     = 32;
    localparam int OUT_DW    = 2 * NCOR * OW;
    localparam int CFG_AW    = 3;

    typedef enum logic [CFG_AW-1:0] {
        REG_XX_XY      = 3'd0,
        REG_XOFF_YX    = 3'd1,
        REG_YY_YOFF    = 3'd2,
        REG_PERSP_XY   = 3'd3,
        REG_PERSP_CONST = 3'd4,
        REG_ORIGIN_XY  = 3'd5,
        REG_DEN_MIN    = 3'd6,
        REG_DEN_MAX    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [TW-1:0] tx;
        logic [TW-1:0] ty;
        logic          stat;
    } t_tile;

    typedef struct packed {
        logic          rej;
        logic          satx;
        logic          saty;
        logic          negx;
        logic          negy;
        logic [DW-1:0] den;
        logic [DW-1:0] remx;
        logic [DW-1:0] remy;
        logic [QW-1:0] wx;
        logic [QW-1:0] wy;
    } t_div;

    function automatic logic signed [NW-1:0] smul(logic signed [HW-1:0] a,
                                                  logic signed [HW-1:0] b);
        smul = a * b;
    endfunction

    function automatic t_div div_step(t_div a);
        t_div        r;
        logic [DW:0] sx;
        logic [DW:0] sy;
        r  = a;
        sx = {a.remx, a.wx[QW-1]};
        sy = {a.remy, a.wy[QW-1]};
        if (sx >= {1'b0, a.den}) begin
            r.remx = DW'(sx - {1'b0, a.den});
            r.wx   = {a.wx[QW-2:0], 1'b1};
        end else begin
            r.remx = sx[DW-1:0];
            r.wx   = {a.wx[QW-2:0], 1'b0};
        end
        if (sy >= {1'b0, a.den}) begin
            r.remy = DW'(sy - {1'b0, a.den});
            r.wy   = {a.wy[QW-2:0], 1'b1};
        end else begin
            r.remy = sy[DW-1:0];
            r.wy   = {a.wy[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [OW-1:0] corner_out(logic [QW-1:0] q, logic neg, logic sat,
                                                 logic signed [HW-1:0] org);
        logic signed [VW-1:0] mag;
        logic signed [VW-1:0] v;
        mag = sat ? VW'(CORNER_CLAMP) : VW'(q);
        v   = neg ? -mag : mag;
        v   = v + (VW'(org) <<< CORNER_FRAC_BITS);
        if (v < -VW'(CORNER_CLAMP)) begin
            v = -VW'(CORNER_CLAMP);
        end
        if (v > VW'(CORNER_CLAMP)) begin
            v = VW'(CORNER_CLAMP);
        end
        return v[OW-1:0];
    endfunction

endpackage

### rtl/core/homography_tile_corner_projection.sv
// top level of the tile corner projection: config registers, projection pipeline
// and 32-stage restoring divider per corner; depends on htcp_pkg
//
// channel  | direction | handshake               | payload
// s_axis   | in        | tvalid / tready         | tdata: tile_x, tile_y; tuser: static_mode
// m_axis   | out       | tvalid / tready         | tdata: corner0_x .. corner3_y
// cfg      | in        | valid / ready           | index, data
//
// one tile enters per cycle when not stalled; stages: offsets, multiplies, sums,
// range check, rounding setup, 32 divider stages, then the output register
// the whole pipeline advances on one enable, held while a result waits untaken
// reset clears the valid bits and loads the register defaults
// cfg writes are always taken
module homography_tile_corner_projection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [htcp_pkg::IN_DW-1:0]           i_s_axis_tdata,  // tile_x, tile_y, zero pad
    input  logic                                 i_s_axis_tuser,  // static_mode
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [htcp_pkg::OUT_DW-1:0]          o_m_axis_tdata,  // c0x c0y c1x c1y c2x c2y c3x c3y
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [htcp_pkg::CFG_AW-1:0]          i_cfg_index,
    input  logic [htcp_pkg::NW-1:0]              i_cfg_data
);
    import htcp_pkg::*;

    logic signed [HW-1:0] r_h [0:8];
    logic signed [HW-1:0] r_ox;
    logic signed [HW-1:0] r_oy;
    logic [29:0]          r_dmin;
    logic [30:0]          r_dmax;

    logic                 en;
    logic                 s_xfer;
    logic [NPIPE:0]       r_vld;
    t_tile                r_tile [0:NPIPE-1];

    logic signed [HW-1:0] r1_cx [0:NCOR-1];
    logic signed [HW-1:0] r1_cy [0:NCOR-1];
    logic signed [NW-1:0] r2_p  [0:NCOR-1][0:5];
    logic [NW-1:0]        r3_nx [0:NCOR-1];
    logic [NW-1:0]        r3_ny [0:NCOR-1];
    logic [NW-1:0]        r3_dn [0:NCOR-1];
    logic [NW-1:0]        r4_ax [0:NCOR-1];
    logic [NW-1:0]        r4_ay [0:NCOR-1];
    logic                 r4_negx [0:NCOR-1];
    logic                 r4_negy [0:NCOR-1];
    logic                 r4_rej  [0:NCOR-1];
    logic [DW-1:0]        r4_den  [0:NCOR-1];
    t_div                 rd [0:DIV_STEPS][0:NCOR-1];
    logic [OUT_DW-1:0]    r_out;

    assign en              = i_m_axis_tready || !r_vld[NPIPE];
    assign o_s_axis_tready = en;
    assign s_xfer          = i_s_axis_tvalid && en;
    assign o_m_axis_tvalid = r_vld[NPIPE];
    assign o_m_axis_tdata  = r_out;
    assign o_cfg_ready     = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= HW'(2097152);
            r_h[1] <= '0;
            r_h[2] <= '0;
            r_h[3] <= '0;
            r_h[4] <= HW'(2097152);
            r_h[5] <= '0;
            r_h[6] <= '0;
            r_h[7] <= '0;
            r_h[8] <= HW'(536870912);
            r_ox   <= '0;
            r_oy   <= '0;
            r_dmin <= 30'd1;
            r_dmax <= 31'd1073741824;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_XX_XY: begin
                    r_h[0] <= i_cfg_data[31:0];
                    r_h[1] <= i_cfg_data[63:32];
                end
                REG_XOFF_YX: begin
                    r_h[2] <= i_cfg_data[31:0];
                    r_h[3] <= i_cfg_data[63:32];
                end
                REG_YY_YOFF: begin
                    r_h[4] <= i_cfg_data[31:0];
                    r_h[5] <= i_cfg_data[63:32];
                end
                REG_PERSP_XY: begin
                    r_h[6] <= i_cfg_data[31:0];
                    r_h[7] <= i_cfg_data[63:32];
                end
                REG_PERSP_CONST: begin
                    r_h[8] <= i_cfg_data[31:0];
                end
                REG_ORIGIN_XY: begin
                    r_ox <= i_cfg_data[31:0];
                    r_oy <= i_cfg_data[63:32];
                end
                REG_DEN_MIN: begin
                    r_dmin <= i_cfg_data[29:0];
                end
                REG_DEN_MAX: begin
                    r_dmax <= i_cfg_data[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NPIPE-1:0], s_xfer};
        end
    end

    // tile fields travel beside the data
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tile[0] <= '{tx: i_s_axis_tdata[TW-1:0], ty: i_s_axis_tdata[2*TW-1:TW],
                           stat: i_s_axis_tuser};
            for (int k = 1; k < NPIPE; k++) begin
                r_tile[k] <= r_tile[k-1];
            end
        end
    end

    // corner offsets relative to origin
    always_ff @(posedge i_clk) begin
        logic [TW:0] px;
        logic [TW:0] py;
        if (en) begin
            for (int c = 0; c < NCOR; c++) begin
                px = {1'b0, i_s_axis_tdata[TW-1:0]} + ((c % 2 == 1) ? (TW+1)'(TILE_SIZE) : '0);
                py = {1'b0, i_s_axis_tdata[2*TW-1:TW]} + ((c >= 2) ? (TW+1)'(TILE_SIZE) : '0);
                r1_cx[c] <= HW'(px) - r_ox;
                r1_cy[c] <= HW'(py) - r_oy;
            end
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCOR; c++) begin
                r2_p[c][0] <= smul(r_h[0], r1_cx[c]);
                r2_p[c][1] <= smul(r_h[1], r1_cy[c]);
                r2_p[c][2] <= smul(r_h[3], r1_cx[c]);
                r2_p[c][3] <= smul(r_h[4], r1_cy[c]);
                r2_p[c][4] <= smul(r_h[6], r1_cx[c]);
                r2_p[c][5] <= smul(r_h[7], r1_cy[c]);
            end
        end
    end

    // numerator and denominator sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCOR; c++) begin
                r3_nx[c] <= r2_p[c][0] + r2_p[c][1] + NW'(r_h[2]);
                r3_ny[c] <= r2_p[c][2] + r2_p[c][3] + NW'(r_h[5]);
                r3_dn[c] <= r2_p[c][4] + r2_p[c][5] + NW'(r_h[8]);
            end
        end
    end

    // denominator range check and magnitudes
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCOR; c++) begin
                r4_rej[c]  <= (r3_dn[c] < NW'(r_dmin)) || (r3_dn[c] >= NW'(r_dmax));
                r4_den[c]  <= r3_dn[c][DW-1:0];
                r4_negx[c] <= r3_nx[c][NW-1];
                r4_negy[c] <= r3_ny[c][NW-1];
                r4_ax[c]   <= r3_nx[c][NW-1] ? -r3_nx[c] : r3_nx[c];
                r4_ay[c]   <= r3_ny[c][NW-1] ? -r3_ny[c] : r3_ny[c];
            end
        end
    end

    // rounding bias and overflow test, divider load
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] mx;
        logic [NW-1:0] my;
        if (en) begin
            for (int c = 0; c < NCOR; c++) begin
                mx = (r4_ax[c] << DIV_SHIFT) + NW'(r4_den[c] >> 1);
                my = (r4_ay[c] << DIV_SHIFT) + NW'(r4_den[c] >> 1);
                rd[0][c].rej  <= r4_rej[c];
                rd[0][c].negx <= r4_negx[c];
                rd[0][c].negy <= r4_negy[c];
                rd[0][c].den  <= r4_den[c];
                rd[0][c].satx <= mx[NW-1:QW] >= QW'(r4_den[c]);
                rd[0][c].saty <= my[NW-1:QW] >= QW'(r4_den[c]);
                rd[0][c].remx <= mx[QW+DW-1:QW];
                rd[0][c].remy <= my[QW+DW-1:QW];
                rd[0][c].wx   <= mx[QW-1:0];
                rd[0][c].wy   <= my[QW-1:0];
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int c = 0; c < NCOR; c++) begin
                    rd[d+1][c] <= div_step(rd[d][c]);
                end
            end
        end
    end

    // static mode, reject, sign, origin, clamp and output register
    always_ff @(posedge i_clk) begin
        t_tile       tl;
        logic [TW:0] px;
        logic [TW:0] py;
        logic [OW-1:0] vx;
        logic [OW-1:0] vy;
        if (en) begin
            tl = r_tile[NPIPE-1];
            for (int c = 0; c < NCOR; c++) begin
                px = {1'b0, tl.tx} + ((c % 2 == 1) ? (TW+1)'(TILE_SIZE) : '0);
                py = {1'b0, tl.ty} + ((c >= 2) ? (TW+1)'(TILE_SIZE) : '0);
                if (tl.stat) begin
                    vx = OW'({px, CORNER_FRAC_BITS'(0)});
                    vy = OW'({py, CORNER_FRAC_BITS'(0)});
                end else if (rd[DIV_STEPS][c].rej) begin
                    vx = OW'(CORNER_CLAMP);
                    vy = OW'(CORNER_CLAMP);
                end else begin
                    vx = corner_out(rd[DIV_STEPS][c].wx, rd[DIV_STEPS][c].negx,
                                    rd[DIV_STEPS][c].satx, r_ox);
                    vy = corner_out(rd[DIV_STEPS][c].wy, rd[DIV_STEPS][c].negy,
                                    rd[DIV_STEPS][c].saty, r_oy);
                end
                r_out[2*c*OW +: OW]     <= vx;
                r_out[(2*c+1)*OW +: OW] <= vy;
            end
        end
    end

`ifndef SYNTH
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted tile did not enter the pipeline");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NPIPE-1] && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("finished tile lost before the output register");
`endif

endmodule

### sim/htcp_corner_checker.sv
// checker for the tile corner projection: watches the config, tile and corner channels,
// predicts the four corners of each accepted tile and compares them field by field
// depends on htcp_pkg
module htcp_corner_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [htcp_pkg::IN_DW-1:0]      i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [htcp_pkg::OUT_DW-1:0]     i_m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [htcp_pkg::CFG_AW-1:0]     i_cfg_index,
    input  logic [htcp_pkg::NW-1:0]         i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count,
    output int                              o_corners_seen
);
    import htcp_pkg::*;

    logic [63:0] r_xx_xy, r_xoff_yx, r_yy_yoff, r_persp_xy, r_origin_xy;
    logic [31:0] r_persp_const;
    logic [29:0] r_den_min;
    logic [30:0] r_den_max;

    logic [OUT_DW-1:0] corners_q[$];

    function automatic logic [OW-1:0] divide_corner(logic [63:0] num, logic [63:0] den,
                                                    longint org);
        logic        neg;
        logic [63:0] mag;
        longint      q;
        longint      v;
        neg = num[63];
        mag = neg ? -num : num;
        mag = (mag << DIV_SHIFT) + (den >> 1);
        if (mag[63:32] >= den) begin
            q = CORNER_CLAMP;
        end else begin
            q = longint'(mag / den);
        end
        v = neg ? -q : q;
        v = v + org * (longint'(1) << CORNER_FRAC_BITS);
        if (v < -longint'(CORNER_CLAMP)) begin
            v = -longint'(CORNER_CLAMP);
        end
        if (v > longint'(CORNER_CLAMP)) begin
            v = CORNER_CLAMP;
        end
        return v[OW-1:0];
    endfunction

    function automatic logic [OUT_DW-1:0] project_tile(logic [TW-1:0] tx, logic [TW-1:0] ty,
                                                       logic st);
        logic [OUT_DW-1:0] res;
        longint      h0, h1, h2, h3, h4, h5, h6, h7, h8, ox, oy, px, py, cx, cy;
        logic [31:0] dx, dy;
        logic [63:0] den, nx, ny;
        res = '0;
        h0 = signed'(r_xx_xy[31:0]);     h1 = signed'(r_xx_xy[63:32]);
        h2 = signed'(r_xoff_yx[31:0]);   h3 = signed'(r_xoff_yx[63:32]);
        h4 = signed'(r_yy_yoff[31:0]);   h5 = signed'(r_yy_yoff[63:32]);
        h6 = signed'(r_persp_xy[31:0]);  h7 = signed'(r_persp_xy[63:32]);
        h8 = signed'(r_persp_const);
        ox = signed'(r_origin_xy[31:0]); oy = signed'(r_origin_xy[63:32]);
        for (int i = 0; i < NCOR; i++) begin
            px = longint'(tx) + (((i & 1) != 0) ? TILE_SIZE : 0);
            py = longint'(ty) + (((i & 2) != 0) ? TILE_SIZE : 0);
            if (st) begin
                res[2*i*OW +: OW]     = OW'(px << CORNER_FRAC_BITS);
                res[(2*i+1)*OW +: OW] = OW'(py << CORNER_FRAC_BITS);
            end else begin
                dx  = 32'(px - ox);
                dy  = 32'(py - oy);
                cx  = signed'(dx);
                cy  = signed'(dy);
                den = h6 * cx + h7 * cy + h8;
                if (den < {34'd0, r_den_min} || den >= {33'd0, r_den_max}) begin
                    res[2*i*OW +: OW]     = OW'(CORNER_CLAMP);
                    res[(2*i+1)*OW +: OW] = OW'(CORNER_CLAMP);
                end else begin
                    nx = h0 * cx + h1 * cy + h2;
                    ny = h3 * cx + h4 * cy + h5;
                    res[2*i*OW +: OW]     = divide_corner(nx, den, ox);
                    res[(2*i+1)*OW +: OW] = divide_corner(ny, den, oy);
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_DW-1:0] want;
        string             fname;
        int                nbad;
        nbad = 0;
        if (!i_rst_n) begin
            r_xx_xy        <= 64'd2097152;
            r_xoff_yx      <= '0;
            r_yy_yoff      <= 64'd2097152;
            r_persp_xy     <= '0;
            r_persp_const  <= 32'd536870912;
            r_origin_xy    <= '0;
            r_den_min      <= 30'd1;
            r_den_max      <= 31'd1073741824;
            corners_q.delete();
            o_pending      <= 0;
            o_fail_count   <= 0;
            o_corners_seen <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_XX_XY:       r_xx_xy       <= i_cfg_data;
                    REG_XOFF_YX:     r_xoff_yx     <= i_cfg_data;
                    REG_YY_YOFF:     r_yy_yoff     <= i_cfg_data;
                    REG_PERSP_XY:    r_persp_xy    <= i_cfg_data;
                    REG_PERSP_CONST: r_persp_const <= i_cfg_data[31:0];
                    REG_ORIGIN_XY:   r_origin_xy   <= i_cfg_data;
                    REG_DEN_MIN:     r_den_min     <= i_cfg_data[29:0];
                    REG_DEN_MAX:     r_den_max     <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_corners_seen <= o_corners_seen + 1;
                if (corners_q.size() == 0) begin
                    $error("corner result with no tile outstanding: %h", i_m_axis_tdata);
                    nbad = 1;
                end else begin
                    want = corners_q.pop_front();
                    for (int k = 0; k < 2 * NCOR; k++) begin
                        if (want[k*OW +: OW] !== i_m_axis_tdata[k*OW +: OW]) begin
                            fname = $sformatf("corner%0d_%s", k / 2, (k % 2) ? "y" : "x");
                            $error("%s: expected %0d, got %0d", fname,
                                   $signed(want[k*OW +: OW]),
                                   $signed(i_m_axis_tdata[k*OW +: OW]));
                            nbad = nbad + 1;
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                corners_q.push_back(project_tile(i_s_axis_tdata[TW-1:0],
                                                 i_s_axis_tdata[2*TW-1:TW], i_s_axis_tuser));
            end
            o_fail_count <= o_fail_count + nbad;
            o_pending    <= corners_q.size();
        end
    end

endmodule

### sim/tb.sv
// top of the tile corner projection testbench: clock, reset, tile and config stimulus,
// random output stalls and the verdict; depends on htcp_pkg and htcp_corner_checker
module tb;
    import htcp_pkg::*;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = NPIPE + 8;
    localparam int CYCLE_LIMIT     = 300000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_DW-1:0]    s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_DW-1:0]   m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_index;
    logic [NW-1:0]       cfg_data;

    int  pending;
    int  fail_count;
    int  corners_seen;
    int  cycles;
    int  tiles_sent;
    bit  src_idle_en;
    bit  sink_stall_en;

    homography_tile_corner_projection dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    htcp_corner_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_corners_seen  (corners_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_tready <= !(sink_stall_en && $urandom_range(99) < 12);
        if (cycles > CYCLE_LIMIT) begin
            $display("homography_tile_corner_projection test failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_small(int span);
        return 32'($urandom_range(2 * span) - span);
    endfunction

    task automatic send_tile(logic [TW-1:0] tx, logic [TW-1:0] ty, logic st);
        bit rdy;
        while (src_idle_en && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DW-2*TW){1'b0}}, ty, tx};
        s_tuser  <= st;
        do begin
            @(negedge i_clk);
            rdy = s_tready;
            @(posedge i_clk);
        end while (!rdy);
        tiles_sent++;
    endtask

    task automatic random_tile();
        logic [TW-1:0] tx, ty;
        tx = TW'($urandom_range(32703));
        ty = TW'($urandom_range(32703));
        send_tile(tx, ty, $urandom_range(99) < 15);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        bit rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge i_clk);
            rdy = cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // stop sending and let the pipeline empty before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_setting(int kind);
        logic [31:0] ox, oy;
        ox = $urandom_range(32767);
        oy = $urandom_range(32767);
        case (kind)
            1: begin // near identity, mild perspective
                write_reg(REG_XX_XY, {rand_small(1 << 16), 32'(2097152) + rand_small(1 << 18)});
                write_reg(REG_XOFF_YX, {rand_small(1 << 16), rand_small(1 << 26)});
                write_reg(REG_YY_YOFF, {rand_small(1 << 26), 32'(2097152) + rand_small(1 << 18)});
                write_reg(REG_PERSP_XY, {rand_small(1 << 11), rand_small(1 << 11)});
                write_reg(REG_PERSP_CONST, 64'(32'd536870912 + rand_small(1 << 26)));
                write_reg(REG_ORIGIN_XY, {oy, ox});
                write_reg(REG_DEN_MIN, 64'($urandom_range(1 << 20)));
                write_reg(REG_DEN_MAX, 64'(1 << 30) + $urandom_range(1 << 29));
            end
            2: begin // everything random, bits above widths included
                write_reg(REG_XX_XY, rand64());
                write_reg(REG_XOFF_YX, rand64());
                write_reg(REG_YY_YOFF, rand64());
                write_reg(REG_PERSP_XY, rand64());
                write_reg(REG_PERSP_CONST, rand64());
                write_reg(REG_ORIGIN_XY, rand64());
                write_reg(REG_DEN_MIN, rand64());
                write_reg(REG_DEN_MAX, rand64());
            end
            3: begin // extreme coefficients, wide origin
                write_reg(REG_XX_XY, {32'h8000_0000, 32'h7fff_ffff});
                write_reg(REG_XOFF_YX, {32'h7fff_ffff, 32'h8000_0000});
                write_reg(REG_YY_YOFF, {32'hffff_ffff, 32'h8000_0000});
                write_reg(REG_PERSP_XY, {32'h0000_0001, 32'hffff_ffff});
                write_reg(REG_PERSP_CONST, 64'h7fff_ffff);
                write_reg(REG_ORIGIN_XY, {32'h7fff_ffff, 32'h8000_0000});
                write_reg(REG_DEN_MIN, 64'd1);
                write_reg(REG_DEN_MAX, 64'h7fff_ffff);
            end
            4: begin // zero denominator allowed through
                write_reg(REG_XX_XY, {rand_small(1 << 22), 32'(2097152)});
                write_reg(REG_XOFF_YX, {rand_small(1 << 22), rand_small(1 << 30)});
                write_reg(REG_PERSP_XY, 64'd0);
                write_reg(REG_PERSP_CONST, 64'd0);
                write_reg(REG_ORIGIN_XY, {oy, ox});
                write_reg(REG_DEN_MIN, 64'd0);
                write_reg(REG_DEN_MAX, 64'hffff_ffff_ffff_ffff);
            end
            5: begin // narrowest window at the top of the range
                write_reg(REG_PERSP_XY, {rand_small(2), rand_small(2)});
                write_reg(REG_PERSP_CONST, 64'h3fff_ffff);
                write_reg(REG_DEN_MIN, 64'h3fff_fff0);
                write_reg(REG_DEN_MAX, 64'h4000_0000);
            end
            6: begin // strong scaling, quotient overflow
                write_reg(REG_XX_XY, {rand_small(1 << 20), 32'(1 << 27)});
                write_reg(REG_XOFF_YX, {32'hfff0_0000, rand_small(1 << 28)});
                write_reg(REG_YY_YOFF, {rand_small(1 << 28), 32'(1 << 17)});
                write_reg(REG_PERSP_XY, {rand_small(1 << 13), rand_small(1 << 13)});
                write_reg(REG_PERSP_CONST, 64'(1 << 24) + $urandom_range(1 << 28));
                write_reg(REG_ORIGIN_XY, {32'hffff_0000 | oy, ox});
                write_reg(REG_DEN_MIN, 64'd1);
                write_reg(REG_DEN_MAX, 64'(1 << 30));
            end
            default: begin // back to the reset values
                write_reg(REG_XX_XY, 64'd2097152);
                write_reg(REG_XOFF_YX, 64'd0);
                write_reg(REG_YY_YOFF, 64'd2097152);
                write_reg(REG_PERSP_XY, 64'd0);
                write_reg(REG_PERSP_CONST, 64'd536870912);
                write_reg(REG_ORIGIN_XY, 64'd0);
                write_reg(REG_DEN_MIN, 64'd1);
                write_reg(REG_DEN_MAX, 64'd1073741824);
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int kinds[NUM_PHASES];
        kinds         = '{1, 2, 3, 4, 5, 6, 1, 0};
        i_rst_n       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = REG_XX_XY;
        cfg_data      = '0;
        cycles        = 0;
        tiles_sent    = 0;
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: field extremes, both modes, static wrap
        send_tile(15'd0, 15'd0, 1'b0);
        send_tile(15'd0, 15'd0, 1'b1);
        send_tile(15'd32703, 15'd32703, 1'b0);
        send_tile(15'd32703, 15'd32703, 1'b1);
        send_tile(15'd32703, 15'd0, 1'b1);
        send_tile(15'd0, 15'd32703, 1'b0);
        send_tile(15'd16384, 15'd8191, 1'b1);
        send_tile(15'd21845, 15'd10922, 1'b0);
        send_tile(15'd10922, 15'd21845, 1'b1);
        for (int i = 0; i < ITEMS_PER_PHASE; i++) random_tile();

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            load_setting(kinds[p]);
            // one setting runs with no gaps on either side
            src_idle_en   = (p != 6);
            sink_stall_en = (p != 6);
            send_tile(15'd0, 15'd0, 1'b0);
            send_tile(15'd32703, 15'd32703, 1'b0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) random_tile();
        end

        s_tvalid <= 1'b0;
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d tiles over %0d register settings, %0d corner sets compared",
                 tiles_sent, NUM_PHASES + 1, corners_seen);
        if (fail_count == 0) begin
            $display("homography_tile_corner_projection test passed");
        end else begin
            $display("homography_tile_corner_projection test failed");
        end
        $finish;
    end

endmodule
